// ----- src/assert_macros.svh -----
// Assertion macros shared by the matrix multiply RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or expression at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- src/mmul_pkg.sv -----
// Shared types and constants for the matrix multiply block.
`timescale 1ns / 1ps
`default_nettype none

package mmul_pkg;

  localparam int FUNC_W = 2;
  localparam int IDX_W  = 3;
  localparam int SIZE_W = 4;
  localparam int K_W    = 4;
  localparam int SUM_W  = 35;
  localparam int CFG_W  = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [FUNC_W-1:0] FUNC_WR_A   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_M_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_N_SIZE = 1'd1;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             rd_first;
    logic             rd_last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [K_W-1:0]   k;
    logic             load_out;
    logic             out_last;
  } mmul_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_free;
  } mmul_status_t;

endpackage

`default_nettype wire

// ----- src/mmul_ctrl.sv -----
// Controller: configuration registers, input handshake and the i/j/k sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mmul_ctrl
  import mmul_pkg::*;
#(
  parameter int MAX_M = 8,
  parameter int MAX_N = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [FUNC_W-1:0]     in_func,
  input  wire mmul_status_t          st,
  output      mmul_cmd_t             cmd
);

  localparam int M_LIM = (MAX_M < 8) ? MAX_M : 8;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [SIZE_W-1:0] m_size_r, n_size_r;
  logic [IDX_W-1:0]  m_last_r, m_last_nxt;
  logic [K_W-1:0]    n_last_r, n_last_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic              accept;
  int                m_eff, n_eff;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_size_r <= SIZE_W'(8);
      n_size_r <= SIZE_W'(8);
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_M_SIZE) m_size_r <= cfg_wdata;
      if (cfg_index == REG_N_SIZE) n_size_r <= cfg_wdata;
    end
  end

  always_comb begin
    m_eff = int'(m_size_r);
    n_eff = int'(n_size_r);
    if (m_eff == 0) m_eff = 1;
    if (m_eff > M_LIM) m_eff = M_LIM;
    if (n_eff == 0) n_eff = 1;
    if (n_eff > MAX_N) n_eff = MAX_N;
  end

  always_comb begin
    state_nxt  = state_r;
    m_last_nxt = m_last_r;
    n_last_nxt = n_last_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    cmd        = '0;
    cmd.i      = i_r;
    cmd.j      = j_r;
    cmd.k      = k_r;
    cmd.out_last = (i_r == m_last_r) && (j_r == m_last_r);
    case (state_r)
      S_IDLE: begin
        cmd.wr_a = accept && (in_func == FUNC_WR_A);
        cmd.wr_b = accept && (in_func == FUNC_WR_B);
        if (accept && (in_func == FUNC_RUN)) begin
          m_last_nxt = IDX_W'(m_eff - 1);
          n_last_nxt = K_W'(n_eff - 1);
          i_nxt      = '0;
          j_nxt      = '0;
          k_nxt      = '0;
          state_nxt  = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (k_r == '0);
        cmd.rd_last  = (k_r == n_last_r);
        if (k_r == n_last_r) begin
          k_nxt     = '0;
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + K_W'(1);
        end
      end
      S_DRAIN: begin
        if (st.acc_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          if (cmd.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ISSUE;
            if (j_r == m_last_r) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      m_last_r <= '0;
      n_last_r <= '0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      m_last_r <= m_last_nxt;
      n_last_r <= n_last_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
    end
  end

  `ASSERT_CLK(a_done_in_drain, st.acc_done |-> (state_r == S_DRAIN), "acc done outside drain")
  `ASSERT_CLK(a_k_in_range, k_r <= n_last_r, "k beyond inner length")
  `ASSERT_CLK(a_ij_in_range, (i_r <= m_last_r) && (j_r <= m_last_r), "i or j beyond side")

endmodule

`default_nettype wire

// ----- src/mmul_dp.sv -----
// Datapath: A and B memories, multiply-accumulate pipeline and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mmul_dp
  import mmul_pkg::*;
#(
  parameter int MAX_M      = 8,
  parameter int MAX_N      = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mmul_cmd_t                    cmd,
  output      mmul_status_t                 st,
  input  wire logic [IDX_W-1:0]             in_row,
  input  wire logic [IDX_W-1:0]             in_col,
  input  wire logic signed [ELEM_WIDTH-1:0] in_value,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [IDX_W-1:0]             out_row,
  output      logic [IDX_W-1:0]             out_col,
  output      logic signed [SUM_W-1:0]      out_sum,
  output      logic                         out_last
);

  localparam int DEPTH = MAX_M * MAX_N;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * ELEM_WIDTH;
  localparam int ACC_W = (PW > SUM_W) ? PW : SUM_W;

  logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] a_rd_r, b_rd_r;
  logic signed [PW-1:0]         prod_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic [AW-1:0]                a_wr_addr, b_wr_addr, a_rd_addr, b_rd_addr;
  logic                         a_wr_ok, b_wr_ok;
  logic                         v1_r, first1_r, last1_r;
  logic                         v2_r, first2_r, last2_r;
  logic                         done_r;
  logic                         out_valid_r, out_last_r;
  logic [IDX_W-1:0]             out_row_r, out_col_r;
  logic signed [SUM_W-1:0]      out_sum_r;

  assign a_wr_ok   = (int'(in_row) < MAX_M) && (int'(in_col) < MAX_N);
  assign b_wr_ok   = (int'(in_row) < MAX_N) && (int'(in_col) < MAX_M);
  assign a_wr_addr = AW'(int'(in_row) * MAX_N + int'(in_col));
  assign b_wr_addr = AW'(int'(in_row) * MAX_M + int'(in_col));
  assign a_rd_addr = AW'(int'(cmd.i) * MAX_N + int'(cmd.k));
  assign b_rd_addr = AW'(int'(cmd.k) * MAX_M + int'(cmd.j));

  always_ff @(posedge clk) begin
    if (cmd.wr_a && a_wr_ok) a_mem[a_wr_addr] <= in_value;
    if (cmd.rd_en) a_rd_r <= a_mem[a_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b && b_wr_ok) b_mem[b_wr_addr] <= in_value;
    if (cmd.rd_en) b_rd_r <= b_mem[b_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (v1_r) prod_r <= a_rd_r * b_rd_r;
    if (v2_r) acc_r <= first2_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      done_r   <= 1'b0;
      first1_r <= 1'b0;
      last1_r  <= 1'b0;
      first2_r <= 1'b0;
      last2_r  <= 1'b0;
    end else begin
      v1_r     <= cmd.rd_en;
      first1_r <= cmd.rd_first;
      last1_r  <= cmd.rd_last;
      v2_r     <= v1_r;
      first2_r <= first1_r;
      last2_r  <= last1_r;
      done_r   <= v2_r && last2_r;
    end
  end

  assign st.acc_done = done_r;
  assign st.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_row_r  <= cmd.i;
      out_col_r  <= cmd.j;
      out_sum_r  <= acc_r[SUM_W-1:0];
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_sum   = out_sum_r;
  assign out_last  = out_last_r;

  `ASSERT_CLK(a_load_when_free, cmd.load_out |-> (!out_valid_r || !out_stall),
              "output register overwritten")
  `ASSERT_NEVER(a_rd_during_write, cmd.rd_en && (cmd.wr_a || cmd.wr_b),
                "read and write in the same cycle")
  `ASSERT_CLK(a_out_hold, (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_sum_r)),
              "stalled result changed")

endmodule

`default_nettype wire

// ----- src/matrix_multiply_core.sv -----
// Matrix multiply C = A*B: sequencer plus shared multiply-accumulate datapath.
// Element writes (A or B) are accepted one per cycle while idle and give no result.
// A compute stalls the input until all m*m results are emitted: per element n reads go
// through the single multiply-accumulate unit, the pipeline drains and the result is emitted.
// Output stalls hold the emit step until the output register is free.
// Synchronous active-low reset sets m_size and n_size to 8; A/B memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_core
  import mmul_pkg::*;
#(
  parameter int MAX_M      = 8,
  parameter int MAX_N      = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_wdata,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic [FUNC_W-1:0]            in_func,
  input  wire logic [IDX_W-1:0]             in_row,
  input  wire logic [IDX_W-1:0]             in_col,
  input  wire logic signed [ELEM_WIDTH-1:0] in_value,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [IDX_W-1:0]             out_row,
  output      logic [IDX_W-1:0]             out_col,
  output      logic signed [SUM_W-1:0]      out_sum,
  output      logic                         out_last
);

  mmul_cmd_t    cmd;
  mmul_status_t st;

  mmul_ctrl #(
    .MAX_M (MAX_M),
    .MAX_N (MAX_N)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .st        (st),
    .cmd       (cmd)
  );

  mmul_dp #(
    .MAX_M      (MAX_M),
    .MAX_N      (MAX_N),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_sum   (out_sum),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire
